// ===== src/swsh_pkg.sv =====
// ----------------------------------------------------------------------------
// swsh_pkg
// Shared types, constants and the sine table generator for the waveshaper.
// ----------------------------------------------------------------------------
`default_nettype none

package swsh_pkg;

  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // limits: M = 2^31-1, Q = M/4, E = M/8
  localparam logic [31:0] QUARTER_LIM  = 32'd536870911;
  localparam logic [31:0] EIGHTH_LIM   = 32'd268435455;
  localparam logic [34:0] QUARTER_HALF = 35'd268435455;
  localparam logic [34:0] EIGHTH_HALF  = 35'd134217727;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // pi/2 in Q1.31
  localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;

  // output scale: M*99, split for two partial products
  localparam logic [37:0] SCALE_K    = 38'd212600881053;
  localparam logic [18:0] SCALE_K_HI = SCALE_K[37:19];
  localparam logic [18:0] SCALE_K_LO = SCALE_K[18:0];

  // ceil(2^41/25): exact floor(z/25) for z < 2^36
  localparam logic [36:0] RECIP_25    = 37'd87960930223;
  localparam logic [17:0] RECIP_25_HI = RECIP_25[36:19];
  localparam logic [18:0] RECIP_25_LO = RECIP_25[18:0];

  typedef enum logic [1:0] {
    BAND_MUTE   = 2'd0,
    BAND_CENTER = 2'd1,
    BAND_UPPER  = 2'd2,
    BAND_LOWER  = 2'd3
  } band_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [31:0] phase;
    band_t       band;
    logic        neg;
  } item_t;

  // per-stage control in the back pipeline
  typedef struct packed {
    band_t band;
    logic  neg;
    logic  qsign;
  } ctl_t;

  function automatic logic [63:0] series_mul(input logic [63:0] term,
                                             input logic [63:0] t2);
    return (term * t2 + (64'd1 << 30)) >> 31;
  endfunction

  // sin(k * (pi/2) / 2^addr_bits) in unsigned Q1.31, Taylor series
  function automatic logic [31:0] sine_entry(input logic [63:0] k,
                                             input int unsigned addr_bits);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    theta = (k * 64'(HALF_PI_Q31) + (64'd1 << (addr_bits - 1))) >> addr_bits;
    t2    = (theta * theta + (64'd1 << 30)) >> 31;
    term  = theta;
    acc   = signed'(theta);
    term  = series_mul(term, t2) / 64'd6;   acc = acc - signed'(term);
    term  = series_mul(term, t2) / 64'd20;  acc = acc + signed'(term);
    term  = series_mul(term, t2) / 64'd42;  acc = acc - signed'(term);
    term  = series_mul(term, t2) / 64'd72;  acc = acc + signed'(term);
    term  = series_mul(term, t2) / 64'd110; acc = acc - signed'(term);
    term  = series_mul(term, t2) / 64'd156; acc = acc + signed'(term);
    term  = series_mul(term, t2) / 64'd210; acc = acc - signed'(term);
    term  = series_mul(term, t2) / 64'd272; acc = acc + signed'(term);
    term  = series_mul(term, t2) / 64'd342; acc = acc - signed'(term);
    if (acc < 0) begin
      return 32'd0;
    end else if (acc > 64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return acc[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/swsh_front.sv =====
// ----------------------------------------------------------------------------
// swsh_front
// Accepts samples, picks the band and works out the sine phase.
// ----------------------------------------------------------------------------
`default_nettype none

module swsh_front import swsh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  logic        f1_valid;
  logic [31:0] f1_ax;
  logic        f1_neg;
  band_t       f1_band;

  logic        in_neg;
  logic [31:0] in_ax;
  band_t       in_band;

  logic [34:0] t4;
  logic [34:0] t8;
  logic [2:0]  c4;
  logic [3:0]  c8;
  logic [31:0] p_c;
  logic [31:0] a8;
  logic [31:0] phase;

  assign s_tready = !f1_valid || !q_full;
  assign in_neg   = s_tdata[31];
  assign in_ax    = in_neg ? (32'd0 - s_tdata) : s_tdata;

  always_comb begin
    if (in_ax > QUARTER_LIM) begin
      in_band = BAND_MUTE;
    end else if (in_ax <= EIGHTH_LIM) begin
      in_band = BAND_CENTER;
    end else if (in_neg) begin
      in_band = BAND_LOWER;
    end else begin
      in_band = BAND_UPPER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (s_tready) begin
      f1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      f1_ax   <= in_ax;
      f1_neg  <= in_neg;
      f1_band <= in_band;
    end
  end

  // round(ax*2^30/E) = 4ax + floor((4ax + E/2)/E), E = 2^28-1
  // round(ax*2^32/Q) = 8ax + floor((8ax + Q/2)/Q), Q = 2^29-1
  always_comb begin
    t4 = {1'b0, f1_ax, 2'b00} + EIGHTH_HALF;
    t8 = {f1_ax, 3'b000} + QUARTER_HALF;
    c4 = 3'd0;
    c8 = 4'd0;
    for (int k = 1; k <= 4; k++) begin
      if (t4 >= 35'(k) * 35'(EIGHTH_LIM)) begin
        c4 = c4 + 3'd1;
      end
    end
    for (int k = 1; k <= 8; k++) begin
      if (t8 >= 35'(k) * 35'(QUARTER_LIM)) begin
        c8 = c8 + 4'd1;
      end
    end
    p_c = {f1_ax[29:0], 2'b00} + 32'(c4);
    a8  = {f1_ax[28:0], 3'b000} + 32'(c8);
  end

  always_comb begin
    case (f1_band)
      BAND_CENTER: phase = p_c;
      BAND_UPPER:  phase = a8 - QUARTER_TURN;
      BAND_LOWER:  phase = QUARTER_TURN - a8;
      default:     phase = 32'd0;
    endcase
  end

  assign q_push       = f1_valid && !q_full;
  assign q_item.phase = phase;
  assign q_item.band  = f1_band;
  assign q_item.neg   = f1_neg;

endmodule

`default_nettype wire

// ===== src/swsh_queue.sv =====
// ----------------------------------------------------------------------------
// swsh_queue
// Small FIFO between the classifier and the sine pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module swsh_queue import swsh_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  output logic  valid,
  output item_t rd_item,
  input  logic  pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t           slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/swsh_back.sv =====
// ----------------------------------------------------------------------------
// swsh_back
// Sine lookup with interpolation, band fold and output scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module swsh_back import swsh_pkg::*; #(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser
);

  localparam int Frac     = 30 - SINE_ADDR_BITS;
  localparam int IdxW     = SINE_ADDR_BITS + 1;
  localparam int RomDepth = (1 << SINE_ADDR_BITS) + 1;
  localparam int DprodW   = Frac + 32;
  localparam int DrW      = Frac + 2;
  localparam int LinPW    = 32 + DrW;
  localparam int LinW     = DrW + 1;
  localparam int DsqW     = 2 * DrW - 31;
  localparam int CurvPW   = 32 + DsqW;
  localparam int Stages   = 10;

  localparam logic [IdxW-1:0] RomTop = IdxW'(1 << SINE_ADDR_BITS);

  logic [31:0] sine_tbl [RomDepth];

  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    assign sine_tbl[k] = sine_entry(64'(k), SINE_ADDR_BITS);
  end

  logic              adv;
  logic [Stages-1:0] vld;
  ctl_t              ctl [Stages];

  // stage 1
  logic [30:0]       u;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   idx1;
  logic [IdxW-1:0]   cidx1;
  logic [Frac-1:0]   d1;
  // stage 2
  logic [31:0]       s2;
  logic [31:0]       c2;
  logic [DrW-1:0]    dr2;
  logic [DprodW-1:0] dprod;
  // stage 3
  logic [31:0]       s3;
  logic [LinW-1:0]   lin3;
  logic [DsqW-1:0]   dsq3;
  logic [LinPW-1:0]  lin_prod;
  logic [2*DrW-1:0]  dsq_prod;
  // stage 4
  logic [31:0]       s4;
  logic [LinW-1:0]   lin4;
  logic [DsqW-1:0]   curv4;
  logic [CurvPW-1:0] curv_prod;
  // stage 5
  logic signed [33:0] sum;
  logic [31:0]       v5;
  logic [31:0]       v_clamp;
  // stage 6
  logic [32:0]       mag6;
  logic [32:0]       mag;
  logic              sign;
  // stage 7..10
  logic [51:0]       kh7;
  logic [51:0]       kl7;
  logic [70:0]       x_sum;
  logic [35:0]       z8;
  logic [53:0]       rh9;
  logic [54:0]       rl9;
  logic [72:0]       y_sum;
  logic [30:0]       w10;

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[Stages-2:0], q_valid};
      m_tvalid <= vld[Stages-1];
    end
  end

  // quarter phase and table addresses
  always_comb begin
    u   = q_item.phase[30] ? (31'h4000_0000 - {1'b0, q_item.phase[29:0]})
                           : {1'b0, q_item.phase[29:0]};
    idx = u[30:Frac];
  end

  always_comb begin
    dprod     = DprodW'(d1) * DprodW'(HALF_PI_Q31) + DprodW'(32'h2000_0000);
    lin_prod  = LinPW'(c2) * LinPW'(dr2) + LinPW'(32'h4000_0000);
    dsq_prod  = (2*DrW)'(dr2) * (2*DrW)'(dr2);
    curv_prod = CurvPW'(s3) * CurvPW'(dsq3) + CurvPW'(32'h8000_0000);
    sum       = 34'(s4) + 34'(lin4) - 34'(curv4);
    if (sum[33]) begin
      v_clamp = 32'd0;
    end else if (sum > 34'sh0_8000_0000) begin
      v_clamp = 32'h8000_0000;
    end else begin
      v_clamp = sum[31:0];
    end
    x_sum = {kh7, 19'd0} + 71'(kl7);
    y_sum = {rh9, 19'd0} + 73'(rl9);
  end

  // fold the sine into the band's shape value, as magnitude and sign
  always_comb begin
    case (ctl[4].band)
      BAND_CENTER: begin
        mag  = {v5, 1'b0};
        sign = ctl[4].neg ^ ctl[4].qsign;
      end
      BAND_UPPER: begin
        mag  = ctl[4].qsign ? (33'h0_8000_0000 - {1'b0, v5})
                            : (33'h0_8000_0000 + {1'b0, v5});
        sign = 1'b0;
      end
      BAND_LOWER: begin
        mag  = ctl[4].qsign ? (33'h0_8000_0000 + {1'b0, v5})
                            : (33'h0_8000_0000 - {1'b0, v5});
        sign = 1'b1;
      end
      default: begin
        mag  = 33'd0;
        sign = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1         <= idx;
      cidx1        <= RomTop - idx;
      d1           <= u[Frac-1:0];
      ctl[0].band  <= q_item.band;
      ctl[0].neg   <= q_item.neg;
      ctl[0].qsign <= q_item.phase[31];

      s2    <= sine_tbl[idx1];
      c2    <= sine_tbl[cidx1];
      dr2   <= dprod[DprodW-1:30];

      s3    <= s2;
      lin3  <= lin_prod[LinPW-1:31];
      dsq3  <= dsq_prod[2*DrW-1:31];

      s4    <= s3;
      lin4  <= lin3;
      curv4 <= curv_prod[CurvPW-1:32];

      v5    <= v_clamp;

      mag6  <= mag;

      kh7   <= 52'(mag6) * 52'(SCALE_K_HI);
      kl7   <= 52'(mag6) * 52'(SCALE_K_LO);

      z8    <= x_sum[69:34];

      rh9   <= 54'(z8) * 54'(RECIP_25_HI);
      rl9   <= 55'(z8) * 55'(RECIP_25_LO);

      w10   <= y_sum[71:41];

      m_tdata <= ctl[Stages-1].neg ? (32'd0 - {1'b0, w10}) : {1'b0, w10};
      m_tuser <= ctl[Stages-1].band;

      for (int i = 1; i < Stages; i++) begin
        if (i != 5) begin
          ctl[i] <= ctl[i-1];
        end
      end
      ctl[5] <= '{band: ctl[4].band, neg: sign, qsign: ctl[4].qsign};
    end
  end

endmodule

`default_nettype wire

// ===== src/sine_waveshaper.sv =====
// ----------------------------------------------------------------------------
// sine_waveshaper
// Folds a signed 32-bit audio sample through a sine shape, one item a cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                    | tuser       | tlast
//  s_*      | in  | [31:0] sample_in         | -           | -
//  m_*      | out | [31:0] shaped_out        | [1:0] band  | -
//
// Sustained rate is one item per cycle while m_tready holds high. An item
// passes one classifier register, the queue, and eleven back stages set by
// the table read and the two split scaling multiplies.
// Reset clears all valid state; the sine table is constant, no fill pass.
// A low m_tready with m_tvalid high freezes the back pipeline; the 4-entry
// queue absorbs items until full, then s_tready drops.
`default_nettype none

module sine_waveshaper import swsh_pkg::*; #(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] shaped_out
  output logic [1:0]  m_tuser    // [1:0] band
);

  logic  q_full;
  logic  q_push;
  logic  q_valid;
  logic  q_pop;
  item_t wr_item;
  item_t rd_item;

  swsh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (wr_item)
  );

  swsh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (wr_item),
    .full    (q_full),
    .valid   (q_valid),
    .rd_item (rd_item),
    .pop     (q_pop)
  );

  swsh_back #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (rd_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== src/swsh_checker.sv =====
// ----------------------------------------------------------------------------
// swsh_checker
// Port-level checks on the waveshaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swsh_checker import swsh_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_reset_state: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("not idle after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled item changed");

  a_mute_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == BAND_MUTE) |-> (m_tdata == 32'd0))
    else $error("muted item not zero");

  a_fold_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser != BAND_UPPER || !m_tdata[31]) &&
                  (m_tuser != BAND_LOWER || m_tdata[31] || m_tdata == 32'd0)))
    else $error("fold band sign wrong");

endmodule

bind sine_waveshaper swsh_checker u_checker (.*);

`default_nettype wire

// ===== verif/sine_waveshaper_checker.sv =====
// ----------------------------------------------------------------------------
// sine_waveshaper_checker
// Watches both stream channels of the waveshaper. For every sample taken in
// it computes the shaped sample and band with a bit-exact fixed-point model
// (quarter-wave table, second-order interpolation, exact 0.99 scaling) and
// compares each result item, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_waveshaper_checker #(
  parameter int ADDR_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_in
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] shaped_out
  input  logic [1:0]  m_tuser,   // [1:0] band
  output int          fail_count,
  output int          due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import swsh_pkg::band_t;
  import swsh_pkg::BAND_MUTE;
  import swsh_pkg::BAND_CENTER;
  import swsh_pkg::BAND_UPPER;
  import swsh_pkg::BAND_LOWER;

  localparam int          TAB_TOP   = 1 << ADDR_BITS;
  localparam int          FRAC      = 30 - ADDR_BITS;
  localparam logic [63:0] FULL      = 64'd2147483647;
  localparam logic [63:0] LIM_Q     = 64'd536870911;
  localparam logic [63:0] LIM_E     = 64'd268435455;
  localparam logic [63:0] HPI       = 64'd3373259426;
  localparam logic [63:0] QTURN     = 64'd1073741824;
  localparam logic signed [63:0] UNIT = 64'sd2147483648;

  typedef struct packed {
    logic [31:0] shaped;
    band_t       band;
  } shaped_t;

  logic [31:0] sine_tab [0:TAB_TOP];
  shaped_t     shaped_due [$];

  function automatic logic [63:0] clamp_unit(input logic signed [63:0] v);
    if (v < 0) return 64'd0;
    if (v > UNIT) return 64'(UNIT);
    return v;
  endfunction

  // sine of a quarter-turn phase u in [0, 2^30], unsigned Q1.31
  function automatic logic signed [63:0] quarter_wave(input logic [63:0] u);
    logic [63:0]        idx, d, s, c, dr, lin, curv;
    logic [ADDR_BITS:0] ti, ci;
    idx = (u >> FRAC) & 64'(2 * TAB_TOP - 1);
    d   = u & ((64'd1 << FRAC) - 64'd1);
    if (idx > 64'(TAB_TOP)) idx = 64'(TAB_TOP);
    ti   = idx[ADDR_BITS:0];
    ci   = (ADDR_BITS+1)'(TAB_TOP) - ti;
    s    = 64'(sine_tab[ti]);
    c    = 64'(sine_tab[ci]);
    dr   = (d * HPI + (64'd1 << 29)) >> 30;
    lin  = (c * dr + (64'd1 << 30)) >> 31;
    curv = (s * ((dr * dr) >> 31) + (64'd1 << 31)) >> 32;
    return signed'(clamp_unit(signed'(s) + signed'(lin) - signed'(curv)));
  endfunction

  // sine of a full-turn phase, signed Q1.31
  function automatic logic signed [63:0] full_wave(input logic [31:0] p);
    logic [63:0]        r;
    logic signed [63:0] v;
    r = {34'd0, p[29:0]};
    v = quarter_wave(p[30] ? (QTURN - r) : r);
    return p[31] ? -v : v;
  endfunction

  // trunc(F * M * 0.99 / 2^32), exact on the magnitude
  function automatic logic [31:0] scale_full(input logic signed [63:0] f);
    logic [63:0] mag, a, q, r, w;
    mag = (f < 0) ? -f : f;
    if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
    a = mag * FULL;
    q = a / 64'd100;
    r = a % 64'd100;
    w = (q * 64'd99 + (r * 64'd99) / 64'd100) >> 32;
    return (f < 0) ? -w[31:0] : w[31:0];
  endfunction

  function automatic shaped_t shape_sample(input logic [31:0] raw);
    logic signed [63:0] x, f;
    logic [63:0]        ax, p, a, ph;
    shaped_t            res;
    x  = {{32{raw[31]}}, raw};
    ax = (x < 0) ? -x : x;
    f  = 0;
    if (ax > LIM_Q) begin
      res.band = BAND_MUTE;
    end else if (ax <= LIM_E) begin
      p = ((ax << 30) + LIM_E / 64'd2) / LIM_E;
      res.band = BAND_CENTER;
      f = 2 * full_wave(p[31:0]);
      if (x < 0) f = -f;
    end else begin
      a = ((ax << 32) + LIM_Q / 64'd2) / LIM_Q;
      if (x > 0) begin
        res.band = BAND_UPPER;
        ph = a - QTURN;
        f = UNIT + full_wave(ph[31:0]);
      end else begin
        res.band = BAND_LOWER;
        ph = QTURN - a;
        f = full_wave(ph[31:0]) - UNIT;
      end
    end
    res.shaped = scale_full(f);
    return res;
  endfunction

  // table entries: Taylor series of sin in Q1.31
  initial begin
    logic [63:0]        theta, t2, term;
    logic signed [63:0] acc;
    for (int k = 0; k <= TAB_TOP; k++) begin
      theta = (64'(k) * HPI + (64'd1 << (ADDR_BITS - 1))) >> ADDR_BITS;
      t2    = (theta * theta + (64'd1 << 30)) >> 31;
      term  = theta;
      acc   = signed'(theta);
      for (int n = 1; n <= 9; n++) begin
        term = ((term * t2 + (64'd1 << 30)) >> 31) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - signed'(term);
        else acc = acc + signed'(term);
      end
      sine_tab[(ADDR_BITS+1)'(k)] = 32'(clamp_unit(acc));
    end
  end

  always @(posedge clk) begin
    shaped_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (shaped_due.size() == 0) begin
          $error("unexpected result item: shaped_out %0d band %0d", $signed(m_tdata), m_tuser);
          fail_count++;
        end else begin
          want = shaped_due.pop_front();
          if (m_tdata !== want.shaped) begin
            $error("shaped_out: expected %0d, actual %0d",
                   $signed(want.shaped), $signed(m_tdata));
            fail_count++;
          end
          if (m_tuser !== want.band) begin
            $error("band: expected %0d, actual %0d", want.band, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) shaped_due.push_back(shape_sample(s_tdata));
      due_count = shaped_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/sine_waveshaper_tb.sv =====
// ----------------------------------------------------------------------------
// sine_waveshaper_tb
// Drives samples into the waveshaper: band edges and extremes first, then
// random samples weighted toward the centre and fold bands. Both sides idle
// in random bursts, the output side holds off once long enough to back up
// the input, and the checker's failure count gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_waveshaper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SINE_BITS   = 10;
  localparam int EDGE_E      = 268435455;
  localparam int EDGE_Q      = 536870911;
  localparam int RAND_ITEMS  = 700;
  localparam int TAIL_ITEMS  = 100;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int NUM_CORNERS = 22;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = 32'd0;   // [31:0] sample_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;            // [31:0] shaped_out
  logic [1:0]  m_tuser;            // [1:0] band
  int          fail_count;
  int          due_count;
  int          n_sent   = 0;
  bit          calm     = 1'b0;
  bit          held     = 1'b0;

  int corner_samples [NUM_CORNERS] = '{
    0, 1, -1, EDGE_E, -EDGE_E, EDGE_E - 1, EDGE_E + 1, -EDGE_E - 1,
    EDGE_Q, -EDGE_Q, EDGE_Q + 1, -EDGE_Q - 1, 32'h7FFF_FFFF, 32'h8000_0000,
    EDGE_E / 2, -EDGE_E / 2, EDGE_E / 2 + 1, (EDGE_E + EDGE_Q) / 2,
    -(EDGE_E + EDGE_Q) / 2, EDGE_Q - EDGE_E / 4, 32'h5555_5555, 32'hAAAA_AAAA
  };

  always #4 clk = ~clk;

  sine_waveshaper #(
    .SINE_ADDR_BITS(SINE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sine_waveshaper_checker #(
    .ADDR_BITS(SINE_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  function automatic int pick_sample();
    int edge_pt;
    case ($urandom_range(0, 9))
      0, 1: return int'($urandom);
      2, 3, 4: return int'($urandom_range(0, 2 * EDGE_Q)) - EDGE_Q;
      5, 6: return int'($urandom_range(0, 2 * EDGE_E)) - EDGE_E;
      7: begin
        case ($urandom_range(0, 3))
          0: edge_pt = EDGE_E;
          1: edge_pt = -EDGE_E;
          2: edge_pt = EDGE_Q;
          default: edge_pt = -EDGE_Q;
        endcase
        return edge_pt + int'($urandom_range(0, 8)) - 4;
      end
      8: return int'($urandom_range(0, 2048)) - 1024;
      default: return int'($urandom_range(0, 4096)) - 2048 +
                      (($urandom_range(0, 1) == 1) ? EDGE_E / 2 : -EDGE_E / 2);
    endcase
  endfunction

  task automatic push_sample(input logic [31:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // output side: random stalls, one long hold-off, none in the tail
  initial begin
    wait (rst == 1'b0);
    forever begin
      if (!held && n_sent >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (corner_samples[i]) push_sample(corner_samples[i]);
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 50 == 0) calm = (k >= RAND_ITEMS - TAIL_ITEMS) || ($urandom_range(0, 2) == 0);
      push_sample(pick_sample());
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (due_count == 0);
    repeat (24) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
